// ===== hdl/ncmq_pkg.sv =====
// Shared types and constants for the nearest cost minimum query block.
package ncmq_pkg;

    localparam int POS_W            = 9;
    localparam int PRICE_W          = 30;
    localparam int COST_W           = 31;
    localparam int MAX_POSITIONS_DEF = 256;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [POS_W-1:0] POS_IN_USE_RESET = POS_W'(256);

    typedef enum logic
    {
        CMD_SET   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic
    {
        REG_POS_IN_USE = 1'b0
    } reg_idx_t;

    // One item traveling down the cell chain, with the running minimum.
    typedef struct packed
    {
        logic                 valid;
        cmd_t                 cmd;
        logic [POS_W-1:0]     pos;
        logic [PRICE_W-1:0]   price;
        logic [COST_W-1:0]    best;
        logic                 found;
    } token_t;

endpackage

// ===== hdl/ncmq_item_if.sv =====
// Input channel interface: set or query items.
interface ncmq_item_if;
    import ncmq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [POS_W-1:0]     position;
    logic [PRICE_W-1:0]   price;

    modport source (output valid, output command, output position, output price, input ready);
    modport sink (input valid, input command, input position, input price, output ready);
endinterface

// ===== hdl/ncmq_result_if.sv =====
// Output channel interface: query results.
interface ncmq_result_if;
    import ncmq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COST_W-1:0]    best_cost;
    logic                 found;

    modport source (output valid, output best_cost, output found, input ready);
    modport sink (input valid, input best_cost, input found, output ready);
endinterface

// ===== hdl/ncmq_cell.sv =====
// One position cell: holds a price and loaded mark, updates the passing token.
module ncmq_cell #(
    parameter int CELL_POS = 1,
    parameter int CPOS_W   = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [CPOS_W-1:0]      active_count,
    input  ncmq_pkg::token_t       tok_in,
    output ncmq_pkg::token_t       tok_out
);
    import ncmq_pkg::*;

    localparam logic [CPOS_W-1:0] MY_POS = CPOS_W'(CELL_POS);

    logic [PRICE_W-1:0] price_reg;
    logic               loaded_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic [CPOS_W-1:0]  pos_ext;
    logic [CPOS_W-1:0]  dist_full;
    logic [COST_W-1:0]  cost;
    logic               hit;

    assign pos_ext   = CPOS_W'(tok_in.pos);
    assign hit       = (pos_ext == MY_POS);
    assign dist_full = (MY_POS >= pos_ext) ? (MY_POS - pos_ext) : (pos_ext - MY_POS);
    // A cell that takes part in a query lies within 1..511, so nine bits of distance suffice.
    assign cost      = {1'b0, price_reg} + COST_W'(dist_full[POS_W-1:0]);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && (tok_in.cmd == CMD_QUERY) && loaded_reg
            && (MY_POS <= active_count))
        begin
            if (!tok_in.found || (cost < tok_in.best))
            begin
                tok_next.best  = cost;
                tok_next.found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            price_reg  <= '0;
            tok_reg    <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
            if (tok_in.valid && (tok_in.cmd == CMD_SET) && hit)
            begin
                loaded_reg <= 1'b1;
                price_reg  <= tok_in.price;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hdl/nearest_cost_min_query_core.sv =====
// Top level: APB register, entry filter, chain of position cells and result register.
//
// Usage
//   item   : sink channel of set (command 0) and query (command 1) items. An item
//            transfers when valid and ready are both high. Items whose position is
//            0 or above the active count are dropped without a result.
//   result : source channel; one transfer per accepted in-range query, carrying
//            best_cost and found (found 0 means no loaded position, best_cost 0).
//   APB    : one register, positions_in_use, at byte address 0 (reset 256).
//            Write it only while no item is in flight.
// Timing
//   Every item walks the chain of MAX_POSITIONS cells, one cell per cycle while
//   the chain advances, then the result register. A new item is taken every
//   cycle as long as the result side keeps up.
// Reset
//   rst_n clears every loaded mark at once, empties the chain and the result
//   register, and restores positions_in_use to 256.
// Stall
//   While a result is held and the receiver is not ready, the whole chain holds
//   and item.ready stays low; nothing is lost or reordered.
module nearest_cost_min_query_core #(
    parameter int MAX_POSITIONS = ncmq_pkg::MAX_POSITIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ncmq_item_if.sink                           item,
    ncmq_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ncmq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ncmq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ncmq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ncmq_pkg::*;

    // Wide enough for the cell positions and for the nine bit item position.
    localparam int CPOS_W = ($clog2(MAX_POSITIONS + 1) > POS_W) ?
                            $clog2(MAX_POSITIONS + 1) : POS_W;
    localparam logic [CPOS_W-1:0] MAX_POS_C = CPOS_W'(MAX_POSITIONS);

    logic [POS_W-1:0]   pos_in_use_reg;
    logic [CPOS_W-1:0]  count_ext;
    logic [CPOS_W-1:0]  active_count;
    logic [CPOS_W-1:0]  item_pos_ext;
    logic               in_range;
    logic               advance;
    logic               cfg_write;
    reg_idx_t           reg_sel;

    token_t             chain [0:MAX_POSITIONS];
    token_t             last_tok;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [COST_W-1:0]  res_cost_reg;
    logic               res_found_reg;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_in_use_reg <= POS_IN_USE_RESET;
        end
        else if (cfg_write && (reg_sel == REG_POS_IN_USE))
        begin
            pos_in_use_reg <= pwdata[POS_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_POS_IN_USE: prdata = APB_DATA_W'(pos_in_use_reg);
            default:        prdata = '0;
        endcase
    end

    // Limit the register to the number of cells built.
    assign count_ext    = CPOS_W'(pos_in_use_reg);
    assign active_count = (count_ext > MAX_POS_C) ? MAX_POS_C : count_ext;

    // ---------------------------------------------------------------- entry
    // The chain moves as one; hold it whenever a result waits unaccepted.
    assign advance      = !res_valid_reg || result.ready;
    assign item.ready   = advance;
    assign item_pos_ext = CPOS_W'(item.position);
    assign in_range     = (item.position != '0) && (item_pos_ext <= active_count);

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = item.valid && in_range;
        chain[0].cmd   = cmd_t'(item.command);
        chain[0].pos   = item.position;
        chain[0].price = item.price;
        chain[0].best  = '0;
        chain[0].found = 1'b0;
    end

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < MAX_POSITIONS; g++)
    begin : g_cell
        ncmq_cell #(
            .CELL_POS (g + 1),
            .CPOS_W   (CPOS_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .active_count (active_count),
            .tok_in       (chain[g]),
            .tok_out      (chain[g+1])
        );
    end

    assign last_tok = chain[MAX_POSITIONS];

    // ---------------------------------------------------------------- result
    // Capture finished queries; set items drop off the end of the chain.
    assign res_valid_next = advance ? (last_tok.valid && (last_tok.cmd == CMD_QUERY))
                                    : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_cost_reg  <= last_tok.best;
            res_found_reg <= last_tok.found;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.best_cost = res_cost_reg;
    assign result.found     = res_found_reg;

    // ---------------------------------------------------------------- checks
    a_rise_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(last_tok.valid && (last_tok.cmd == CMD_QUERY)))
        else $error("result raised without a query at the chain end");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_found_reg) |-> (res_cost_reg == '0))
        else $error("not-found result carries a nonzero cost");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(last_tok.valid) && $stable(last_tok.best))
        else $error("chain moved while the result was stalled");

endmodule

// ===== dv/nearest_cost_min_query_core_test.sv =====
// Self-checking testbench for nearest_cost_min_query_core: directed, register and random traffic.
module nearest_cost_min_query_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ncmq_pkg::*;

    // Chain length matches the default build of the block.
    localparam int NPOS          = MAX_POSITIONS_DEF;
    // Time for an item to pass every cell and the result register.
    localparam int LATENCY       = NPOS + 1;
    // Quiet time after the last quote so that trailing set items leave the chain.
    localparam int SETTLE_CYCLES = LATENCY + 16;
    // Long receiver hold-off: longer than the chain so the input side must stall.
    localparam int HOLD_CYCLES   = 700;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 5000;
    localparam int GAP_PCT       = 15;
    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

    typedef struct packed
    {
        logic [COST_W-1:0] best_cost;
        logic              found;
    } quote_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ncmq_item_if   item_ch();
    ncmq_result_if result_ch();

    // Shadow copy of the block's state: the register and the price book.
    logic [POS_W-1:0]   span_reg;
    logic [PRICE_W-1:0] book_price [NPOS];
    logic               book_loaded [NPOS];

    // Quotes owed by the block, oldest first.
    quote_t pending_quotes [$];
    quote_t oldest_quote;

    int errors          = 0;
    bit gaps_on         = 1'b1;
    int holds_requested = 0;
    int idle_cycles     = 0;

    nearest_cost_min_query_core #(
        .MAX_POSITIONS (NPOS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp the register to the chain length; a value above capacity means all cells.
    function automatic int active_span();
        return (int'(span_reg) > NPOS) ? NPOS : int'(span_reg);
    endfunction

    // Cheapest price plus travel distance over every loaded position in range.
    function automatic quote_t cheapest_reach(int from_pos);
        quote_t            q;
        logic [COST_W-1:0] cost;
        int                travel;
        q = '0;
        for (int i = 1; i <= active_span(); i++)
        begin
            if (book_loaded[i-1])
            begin
                travel = (i >= from_pos) ? (i - from_pos) : (from_pos - i);
                cost   = COST_W'(book_price[i-1]) + COST_W'(travel);
                if (!q.found || cost < q.best_cost)
                begin
                    q.best_cost = cost;
                    q.found     = 1'b1;
                end
            end
        end
        return q;
    endfunction

    // Update the book for one accepted item; queue a quote for an in-range query.
    function automatic void apply_item(cmd_t c, logic [POS_W-1:0] p, logic [PRICE_W-1:0] pr);
        if (p == '0 || int'(p) > active_span())
            return;
        if (c == CMD_SET)
        begin
            book_price[p-1]  = pr;
            book_loaded[p-1] = 1'b1;
        end
        else
            pending_quotes.push_back(cheapest_reach(int'(p)));
    endfunction

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Offer one item, idling first at random, and hold it until its transfer.
    // Return at the falling edge with valid still high.
    task automatic send_item(cmd_t c, logic [POS_W-1:0] p, logic [PRICE_W-1:0] pr);
        while (gaps_on && $urandom_range(0, 99) < GAP_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.command  <= c;
        item_ch.position <= p;
        item_ch.price    <= pr;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        apply_item(c, p, pr);
        @(negedge clk);
    endtask

    // Drop valid at the end of a burst.
    task automatic stop_items();
        item_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for every owed quote, then let trailing set items leave the chain.
    task automatic drain();
        while (pending_quotes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Random mix: mostly in-range positions, a few raw 9-bit positions as noise;
    // prices mostly near the distances so that travel cost matters.
    task automatic send_random(int count, int query_pct);
        cmd_t               c;
        logic [POS_W-1:0]   p;
        logic [PRICE_W-1:0] pr;
        int                 span;
        int                 pick;
        for (int n = 0; n < count; n++)
        begin
            span = active_span();
            c    = ($urandom_range(0, 99) < query_pct) ? CMD_QUERY : CMD_SET;
            pick = $urandom_range(0, 99);
            if (pick < 6 || span == 0)
                p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            else
                p = POS_W'($urandom_range(1, span));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                pr = PRICE_W'($urandom_range(0, 4 * span + 4));
            else if (pick < 90)
                pr = PRICE_W'($urandom());
            else if (pick < 95)
                pr = PRICE_MAX;
            else
                pr = '0;
            send_item(c, p, pr);
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Write positions_in_use, then read it back. Call only while the block is idle.
    task automatic write_span(logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(REG_POS_IN_USE));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The register takes the low bits at this edge; upper bits are dropped.
        span_reg = value[POS_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[POS_W-1:0] !== span_reg)
        begin
            $display("%0t register readback: expected %0d actual %0d",
                     $time, span_reg, prdata[POS_W-1:0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready with random gaps, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int hold_left;
        int holds_served;
        hold_left       = 0;
        holds_served    = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_requested)
            begin
                holds_served = holds_requested;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 99) < GAP_PCT)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest owed quote.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_quotes.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual best_cost %0d found %0d",
                         $time, result_ch.best_cost, result_ch.found);
                errors++;
            end
            else
            begin
                oldest_quote = pending_quotes.pop_front();
                if (result_ch.best_cost !== oldest_quote.best_cost)
                begin
                    $display("%0t best_cost mismatch: expected %0d actual %0d",
                             $time, oldest_quote.best_cost, result_ch.best_cost);
                    errors++;
                end
                if (result_ch.found !== oldest_quote.found)
                begin
                    $display("%0t found mismatch: expected %0d actual %0d",
                             $time, oldest_quote.found, result_ch.found);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("nearest_cost_min_query_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty book, out-of-range positions, extreme prices and costs, repeated set.
    task automatic check_empty_and_extremes();
        send_item(CMD_QUERY, 9'd1, '0);             // nothing loaded: not found
        send_item(CMD_QUERY, 9'd256, '0);
        send_item(CMD_QUERY, 9'd0, '0);             // position zero: dropped
        send_item(CMD_SET, 9'd0, 30'd5);
        send_item(CMD_SET, 9'd257, 30'd5);          // above active count: dropped
        send_item(CMD_QUERY, 9'd511, '0);
        send_item(CMD_SET, 9'd256, PRICE_MAX);
        send_item(CMD_QUERY, 9'd1, '0);             // largest possible cost
        send_item(CMD_SET, 9'd1, '0);
        send_item(CMD_QUERY, 9'd1, '0);
        send_item(CMD_QUERY, 9'd256, '0);           // distance beats the top price
        send_item(CMD_SET, 9'd256, 30'd3);          // replace a loaded price
        send_item(CMD_QUERY, 9'd200, '0);
        send_item(CMD_QUERY, 9'd256, '0);
        send_item(CMD_SET, 9'd128, 30'h2AAA_AAAA);
        send_item(CMD_SET, 9'd129, 30'h1555_5555);
        send_item(CMD_QUERY, 9'd128, '0);
        stop_items();
        drain();
    endtask

    // Register at zero, one, above capacity, shrink and grow back.
    task automatic check_span_register();
        // Zero: every item is dropped, the set must not land.
        write_span('0);
        send_item(CMD_SET, 9'd1, 30'd7);
        send_item(CMD_QUERY, 9'd1, '0);
        stop_items();
        drain();
        // One position only; junk above the register width is ignored.
        write_span(32'hFFFF_FE01);
        send_item(CMD_QUERY, 9'd1, '0);
        send_item(CMD_QUERY, 9'd2, '0);
        send_item(CMD_SET, 9'd1, 30'd9);
        send_item(CMD_QUERY, 9'd1, '0);
        stop_items();
        drain();
        // Above capacity: clamps to the full chain.
        write_span(32'd511);
        send_item(CMD_QUERY, 9'd256, '0);
        send_item(CMD_QUERY, 9'd1, '0);
        stop_items();
        drain();
        write_span(32'd300);
        send_item(CMD_SET, 9'd255, 30'd40);
        send_item(CMD_QUERY, 9'd254, '0);
        stop_items();
        drain();
        // Shrink: upper entries are hidden but kept.
        write_span(32'd2);
        send_item(CMD_QUERY, 9'd2, '0);
        send_item(CMD_SET, 9'd3, 30'd0);
        stop_items();
        drain();
        // Grow back: hidden entries take part again.
        write_span(32'd256);
        send_item(CMD_QUERY, 9'd256, '0);
        send_item(CMD_QUERY, 9'd3, '0);
        stop_items();
        drain();
    endtask

    // Random phases over several register settings; one phase runs without gaps.
    task automatic check_random_traffic();
        logic [APB_DATA_W-1:0] spans [6];
        spans[0] = 32'd256;
        spans[1] = APB_DATA_W'($urandom_range(2, 16));
        spans[2] = 32'd511;
        spans[3] = APB_DATA_W'($urandom_range(17, 255));
        spans[4] = 32'd2;
        spans[5] = (APB_DATA_W'($urandom()) & ~APB_DATA_W'((1 << POS_W) - 1)) | 32'd256;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_span(spans[ph]);
            gaps_on = (ph != 2);
            send_random(200, 55);
            stop_items();
            drain();
        end
        gaps_on = 1'b1;
    endtask

    // Hold the receiver off long enough for the chain to fill and block the input.
    task automatic check_backpressure();
        write_span(32'd256);
        holds_requested++;
        send_random(350, 85);
        stop_items();
        drain();
    endtask

    initial
    begin : main_sequence
        item_ch.valid    = 1'b0;
        item_ch.command  = CMD_SET;
        item_ch.position = '0;
        item_ch.price    = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        span_reg         = POS_IN_USE_RESET;
        for (int i = 0; i < NPOS; i++)
        begin
            book_price[i]  = '0;
            book_loaded[i] = 1'b0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        check_empty_and_extremes();
        check_span_register();
        check_random_traffic();
        check_backpressure();

        if (errors == 0)
            $display("nearest_cost_min_query_core regression: pass");
        else
            $display("nearest_cost_min_query_core regression: fail");
        $finish;
    end

endmodule
